// ----- design/usbcd_pkg.sv -----
// Shared types, divider constants and calendar tables for the epoch-to-BCD converter.
package usbcd_pkg;

   // Reciprocal multipliers: q = (x * M) >> S gives floor(x / d) for the stated width of x
   localparam logic [30:0] DIV15_M30   = 31'd1145324613; // x: 30 bits, shift 34
   localparam logic [24:0] DIV15_M25   = 25'd17895698;   // x: 25 bits below 17895698, shift 28
   localparam logic [18:0] DIV3_M18    = 19'd349526;     // x: 18 bits, shift 20
   localparam logic [16:0] DIV1461_M16 = 17'd91868;      // x: 16 bits, shift 27

   // Four-year cycle, counted from 1970; the third year of each cycle is the leap year
   localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
   localparam logic [7:0]  YEAR_FIRST  = 8'd30;  // 2000 as years since 1970
   localparam logic [7:0]  YEAR_LAST   = 8'd129; // 2099 as years since 1970
   localparam logic [1:0]  LEAP_YIC    = 2'd2;

   localparam logic [10:0] YEAR_START [4] = '{11'd0, 11'd365, 11'd730, 11'd1096};

   localparam logic [8:0] MONTH_START_COMMON [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

   localparam logic [8:0] MONTH_START_LEAP [12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

   // Time of day plus whole days since the epoch
   typedef struct packed {
      logic [15:0] days;
      logic [4:0]  hrs;
      logic [5:0]  mins;
      logic [5:0]  secs;
   } time_type;

   // Binary calendar fields ahead of BCD conversion
   typedef struct packed {
      logic        oor;
      logic [6:0]  year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hrs;
      logic [5:0]  mins;
      logic [5:0]  secs;
   } date_type;

   // Packed BCD of a value below 100
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] ones;
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (v >= 7'(k * 10)) begin
            tens = 4'(k);
         end
      end
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

// ----- design/usbcd_time_split.sv -----
// Four-stage split of a second count into days, hours, minutes and seconds.
module usbcd_time_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         in_seconds,
   output logic                out_valid,
   input  logic                out_ready,
   output usbcd_pkg::time_type out_time
);
   import usbcd_pkg::*;

   logic [3:0]  vld_ff;
   logic [3:0]  vld_in;
   logic [3:0]  en;

   logic [60:0] prod1;
   logic [48:0] prod2;
   logic [36:0] prod3;

   logic [26:0] q1_ff, q1_in;
   logic [5:0]  tlo_ff;
   logic [20:0] q2_ff, q2_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  q1lo_ff;
   logic [15:0] days_ff, days_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  q2lo_ff;
   logic [5:0]  sec3_ff;
   time_type    out_ff, out_in;

   // Stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[3] = !vld_ff[3] || out_ready;
      for (int i = 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign vld_in   = {vld_ff[2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage 1: minutes since epoch = t / 60 = (t >> 2) / 15
   assign prod1 = 61'(in_seconds[31:2]) * 61'(DIV15_M30);
   assign q1_in = prod1[60:34];

   // Stage 2: hours = minutes / 60; seconds = t - 60*q1 mod 64 = t + 4*q1
   assign prod2  = 49'(q1_ff[26:2]) * 49'(DIV15_M25);
   assign q2_in  = prod2[48:28];
   assign sec_in = tlo_ff + {q1_ff[3:0], 2'b00};

   // Stage 3: days = hours / 24 = (hours >> 3) / 3; minute remainder
   assign prod3  = 37'(q2_ff[20:3]) * 37'(DIV3_M18);
   assign days_in = prod3[35:20];
   assign min_in  = q1lo_ff + {q2_ff[3:0], 2'b00};

   // Stage 4: hour remainder = hours - 24*days, mod 32
   always_comb begin
      out_in.days = days_ff;
      out_in.hrs  = q2lo_ff - ({days_ff[1:0], 3'b000} + {days_ff[0], 4'b0000});
      out_in.mins = min_ff;
      out_in.secs = sec3_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         q1_ff  <= q1_in;
         tlo_ff <= in_seconds[5:0];
      end
      if (en[1]) begin
         q2_ff   <= q2_in;
         sec_ff  <= sec_in;
         q1lo_ff <= q1_ff[5:0];
      end
      if (en[2]) begin
         days_ff <= days_in;
         min_ff  <= min_in;
         q2lo_ff <= q2_ff[4:0];
         sec3_ff <= sec_ff;
      end
      if (en[3]) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_time  = out_ff;

endmodule

// ----- design/usbcd_date_split.sv -----
// Three-stage split of a day count into year, month and day of month.
module usbcd_date_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  usbcd_pkg::time_type in_time,
   output logic                out_valid,
   input  logic                out_ready,
   output usbcd_pkg::date_type out_date
);
   import usbcd_pkg::*;

   logic [2:0]  vld_ff;
   logic [2:0]  vld_in;
   logic [2:0]  en;

   logic [32:0] prod4;
   logic [16:0] cyc_mul;

   logic [5:0]  cyc_ff, cyc_in;
   time_type    t1_ff;
   logic [10:0] rem_ff, rem_in;
   logic [1:0]  yic_ff, yic_in;
   logic [7:0]  yearf_ff, yearf_in;
   time_type    t2_ff;
   date_type    out_ff, out_in;

   logic [10:0] doy_full;
   logic [8:0]  doy;
   logic        leap;
   logic [3:0]  mon;
   logic [8:0]  mstart;
   logic [8:0]  dom;
   logic [7:0]  yoff;

   always_comb begin
      en[2] = !vld_ff[2] || out_ready;
      for (int i = 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign vld_in   = {vld_ff[1:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage 1: four-year cycles = days / 1461
   assign prod4  = 33'(in_time.days) * 33'(DIV1461_M16);
   assign cyc_in = prod4[32:27];

   // Stage 2: day within cycle, year within cycle, years since 1970
   assign cyc_mul = 17'(cyc_ff) * 17'(CYCLE_DAYS);
   assign rem_in  = t1_ff.days[10:0] - cyc_mul[10:0];

   always_comb begin
      priority if (rem_in >= YEAR_START[3]) begin
         yic_in = 2'd3;
      end else if (rem_in >= YEAR_START[2]) begin
         yic_in = 2'd2;
      end else if (rem_in >= YEAR_START[1]) begin
         yic_in = 2'd1;
      end else begin
         yic_in = 2'd0;
      end
   end

   assign yearf_in = {cyc_ff, 2'b00} + 8'(yic_in);

   // Stage 3: range check, month search and day of month
   assign doy_full = rem_ff - YEAR_START[yic_ff];
   assign doy      = doy_full[8:0];
   assign leap     = (yic_ff == LEAP_YIC);

   always_comb begin
      mon = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy >= (leap ? MONTH_START_LEAP[k] : MONTH_START_COMMON[k])) begin
            mon = 4'(k);
         end
      end
   end

   assign mstart = leap ? MONTH_START_LEAP[mon] : MONTH_START_COMMON[mon];
   assign dom    = doy - mstart + 9'd1;
   assign yoff   = yearf_ff - YEAR_FIRST;

   always_comb begin
      out_in.oor   = (yearf_ff < YEAR_FIRST) || (yearf_ff > YEAR_LAST);
      out_in.year  = yoff[6:0];
      out_in.month = mon + 4'd1;
      out_in.day   = dom[4:0];
      out_in.hrs   = t2_ff.hrs;
      out_in.mins  = t2_ff.mins;
      out_in.secs  = t2_ff.secs;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cyc_ff <= cyc_in;
         t1_ff  <= in_time;
      end
      if (en[1]) begin
         rem_ff   <= rem_in;
         yic_ff   <= yic_in;
         yearf_ff <= yearf_in;
         t2_ff    <= t1_ff;
      end
      if (en[2]) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_date  = out_ff;

endmodule

// ----- design/usbcd_bcd_out.sv -----
// BCD conversion and output register of the result stream.
module usbcd_bcd_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  usbcd_pkg::date_type in_date,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [39:0]         out_data,
   output logic                out_flag
);
   import usbcd_pkg::*;

   logic        vld_ff;
   logic        en;
   logic [39:0] data_ff, data_in;
   logic        flag_ff;
   logic [7:0]  b_year, b_month, b_day, b_hrs, b_mins, b_secs;

   assign en       = !vld_ff || out_ready;
   assign in_ready = en;

   // Digit conversion of each field
   assign b_year  = to_bcd(in_date.year);
   assign b_month = to_bcd(7'(in_date.month));
   assign b_day   = to_bcd(7'(in_date.day));
   assign b_hrs   = to_bcd(7'(in_date.hrs));
   assign b_mins  = to_bcd(7'(in_date.mins));
   assign b_secs  = to_bcd(7'(in_date.secs));

   // Out-of-range results carry all-zero fields
   always_comb begin
      if (in_date.oor) begin
         data_in = '0;
      end else begin
         data_in = {1'b0, b_secs[6:0], b_mins[6:0], b_hrs[5:0], b_day[5:0],
                    b_month[4:0], b_year};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         flag_ff <= in_date.oor;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;
   assign out_flag  = flag_ff;

endmodule

// ----- design/unix_seconds_to_bcd_datetime.sv -----
// Top level: Unix seconds in, BCD calendar date and time out.
// Takes one 32-bit Unix timestamp per transfer and returns one result per transfer with the
// date and time in packed BCD (two-digit year after 2000). A new timestamp can be taken on
// every clock cycle unless the result side stalls; each one passes through eight pipeline
// register stages (four for the reciprocal-multiply divisions by 60, 60 and 24 and the hour
// remainder, three for the four-year-cycle division, the year lookup and the month lookup, and
// the BCD output register). When the result side stalls, empty stages still fill, so input is
// taken until the pipeline is full.
// Timestamps outside 2000-2099 return rsp_tuser = 1 with all tdata fields zero.
module unix_seconds_to_bcd_datetime (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] epoch_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [7:0] bcd_year, [12:8] bcd_month, [18:13] bcd_day,
                                   // [24:19] bcd_hours, [31:25] bcd_minutes,
                                   // [38:32] bcd_seconds, [39] zero
   output logic        rsp_tuser   // out_of_range
);
   import usbcd_pkg::*;

   logic     time_valid, time_ready;
   time_type time_data;
   logic     date_valid, date_ready;
   date_type date_data;

   usbcd_time_split u_time_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_seconds (req_tdata),
      .out_valid  (time_valid),
      .out_ready  (time_ready),
      .out_time   (time_data)
   );

   usbcd_date_split u_date_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (time_valid),
      .in_ready  (time_ready),
      .in_time   (time_data),
      .out_valid (date_valid),
      .out_ready (date_ready),
      .out_date  (date_data)
   );

   usbcd_bcd_out u_bcd_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (date_valid),
      .in_ready  (date_ready),
      .in_date   (date_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_flag  (rsp_tuser)
   );

endmodule

// ----- design/usbcd_checker.sv -----
// Port-level checks for the epoch-to-BCD converter, bound to the top level.
module usbcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Pipeline comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Out-of-range results carry zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("out-of-range result has nonzero fields");

   // In-range month is 01..12
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[12:8] != 5'h00 && rsp_tdata[12:8] <= 5'h12
                                   && rsp_tdata[11:8] <= 4'd9)
      else $error("month out of range");

   // Seconds and minutes are legal BCD below 60
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:32] <= 4'd9 && rsp_tdata[38:36] <= 3'd5
                     && rsp_tdata[28:25] <= 4'd9 && rsp_tdata[31:29] <= 3'd5)
      else $error("seconds or minutes not valid BCD");

endmodule

bind unix_seconds_to_bcd_datetime usbcd_checker u_usbcd_checker (.*);
